>>> rtl/sscp_pkg.sv
// ----------------------------------------------------------------------------
// sscp_pkg
// shared types and constants of the serial setpoint command parser
// ----------------------------------------------------------------------------
`default_nettype none

package sscp_pkg;

   // number of setpoint digits, most significant first
   localparam logic [1:0] NUM_DIGITS = 2'd3;

   localparam logic [7:0]  BACKSLASH_CHAR = 8'h5C;
   localparam logic [7:0]  S_CHAR         = 8'h73;
   localparam logic [7:0]  ZERO_CHAR      = 8'h30;
   localparam logic [14:0] MAX_DEGREES    = 15'd359;
   localparam logic [7:0]  MAX_OFFSET     = 8'd2;

   // register reset values
   localparam logic [7:0]  PAN_CODE_RST      = 8'd112;
   localparam logic [7:0]  TILT_CODE_RST     = 8'd116;
   localparam logic [7:0]  MAX_PWM_CODE_RST  = 8'd109;
   localparam logic [7:0]  STOP_CODE_RST     = 8'd120;
   localparam logic [15:0] DIGIT_TIMEOUT_RST = 16'd50000;

   // register indexes
   localparam logic [2:0] CSR_PAN_CODE      = 3'd0;
   localparam logic [2:0] CSR_TILT_CODE     = 3'd1;
   localparam logic [2:0] CSR_MAX_PWM_CODE  = 3'd2;
   localparam logic [2:0] CSR_STOP_CODE     = 3'd3;
   localparam logic [2:0] CSR_DIGIT_TIMEOUT = 3'd4;

   // request kinds
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // result kinds
   localparam logic [2:0] KIND_PAN_SETPOINT  = 3'd0;
   localparam logic [2:0] KIND_TILT_SETPOINT = 3'd1;
   localparam logic [2:0] KIND_PAN_OFFSET    = 3'd2;
   localparam logic [2:0] KIND_TILT_OFFSET   = 3'd3;
   localparam logic [2:0] KIND_MAX_PWM       = 3'd4;
   localparam logic [2:0] KIND_STOP          = 3'd5;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_COMMAND = 5'b00010,
      PH_TARGET  = 5'b00100,
      PH_DIGITS  = 5'b01000,
      PH_OFFSET  = 5'b10000
   } phase_type;

endpackage

`default_nettype wire

>>> rtl/serial_setpoint_command_parser.sv
// ----------------------------------------------------------------------------
// serial_setpoint_command_parser
// parses backslash, 's', target code, setpoint digits and offset from a
// stream of received bytes and timer ticks, emitting setpoint and event results
// ----------------------------------------------------------------------------
//  channel | direction | ports                          | accepted when
//  --------+-----------+--------------------------------+-----------------------
//  req     | in        | req_cmd, req_rx_byte           | req_valid & req_ready
//  rsp     | out       | rsp_event_kind, rsp_event_value| rsp_valid & rsp_ready
//  csr     | in        | csr_index, csr_wdata           | csr_valid & csr_ready
//
//  one request per cycle while req_ready is high: parse state updates in the
//  cycle a request is taken, its result (if any) sits in the result register
//  from the next cycle; req_ready drops only while a result waits there and
//  rsp_ready is low, so requests stall only while the consumer holds off
//  csr_ready is always high; writes take effect on the next request
//  synchronous active-high reset restores register defaults and the idle phase
// ----------------------------------------------------------------------------
`default_nettype none

module serial_setpoint_command_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_cmd,
   input  wire logic [7:0]  req_rx_byte,
   // result channel
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [2:0]  rsp_event_kind,
   output      logic [8:0]  rsp_event_value,
   // configuration channel
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   import sscp_pkg::*;

   // configuration registers
   logic [7:0]  pan_code_ff;
   logic [7:0]  tilt_code_ff;
   logic [7:0]  max_pwm_code_ff;
   logic [7:0]  stop_code_ff;
   logic [15:0] digit_timeout_ff;

   // parse state
   phase_type   phase_ff, phase_in;
   logic        axis_is_tilt_ff, axis_is_tilt_in;
   logic [1:0]  digit_count_ff, digit_count_in;
   logic [14:0] value_accum_ff, value_accum_in;
   logic [15:0] idle_ticks_ff, idle_ticks_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_kind_ff, rsp_kind_in;
   logic [8:0]  rsp_value_ff, rsp_value_in;

   logic        req_fire;
   logic        emit;
   logic [2:0]  emit_kind;
   logic [8:0]  emit_value;
   logic [7:0]  digit;
   logic [14:0] accum_new;
   logic [1:0]  count_new;
   logic [16:0] ticks_new;

   // the result register frees up in the same cycle it is taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = rsp_kind_ff;
   assign rsp_event_value = rsp_value_ff;

   // digit value wraps mod 256 for non-digit bytes
   assign digit     = req_rx_byte - ZERO_CHAR;
   // value * 10 + digit, kept to 15 bits
   assign accum_new = (value_accum_ff << 3) + (value_accum_ff << 1) + {7'd0, digit};
   assign count_new = digit_count_ff + 2'd1;
   assign ticks_new = {1'b0, idle_ticks_ff} + 17'd1;

   // configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         pan_code_ff      <= PAN_CODE_RST;
         tilt_code_ff     <= TILT_CODE_RST;
         max_pwm_code_ff  <= MAX_PWM_CODE_RST;
         stop_code_ff     <= STOP_CODE_RST;
         digit_timeout_ff <= DIGIT_TIMEOUT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PAN_CODE:      pan_code_ff      <= csr_wdata[7:0];
            CSR_TILT_CODE:     tilt_code_ff     <= csr_wdata[7:0];
            CSR_MAX_PWM_CODE:  max_pwm_code_ff  <= csr_wdata[7:0];
            CSR_STOP_CODE:     stop_code_ff     <= csr_wdata[7:0];
            CSR_DIGIT_TIMEOUT: digit_timeout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // parse step for one request
   always_comb begin
      phase_in        = phase_ff;
      axis_is_tilt_in = axis_is_tilt_ff;
      digit_count_in  = digit_count_ff;
      value_accum_in  = value_accum_ff;
      idle_ticks_in   = idle_ticks_ff;
      emit            = 1'b0;
      emit_kind       = KIND_STOP;
      emit_value      = 9'd0;

      if (req_cmd == CMD_TICK) begin
         // ticks only count while waiting for a digit or the offset
         if (phase_ff inside {PH_DIGITS, PH_OFFSET}) begin
            if (ticks_new >= {1'b0, digit_timeout_ff}) begin
               phase_in       = PH_IDLE;
               digit_count_in = 2'd0;
               value_accum_in = 15'd0;
               idle_ticks_in  = 16'd0;
            end else begin
               idle_ticks_in = ticks_new[15:0];
            end
         end
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               if (req_rx_byte == BACKSLASH_CHAR) phase_in = PH_COMMAND;
            end
            PH_COMMAND: begin
               if (req_rx_byte == S_CHAR) begin
                  phase_in = PH_TARGET;
               end else begin
                  phase_in       = PH_IDLE;
                  digit_count_in = 2'd0;
                  value_accum_in = 15'd0;
                  idle_ticks_in  = 16'd0;
               end
            end
            PH_TARGET: begin
               phase_in       = PH_IDLE;
               digit_count_in = 2'd0;
               value_accum_in = 15'd0;
               idle_ticks_in  = 16'd0;
               // first matching code wins: pan, tilt, max pwm, stop
               if (req_rx_byte == pan_code_ff) begin
                  phase_in        = PH_DIGITS;
                  axis_is_tilt_in = 1'b0;
               end else if (req_rx_byte == tilt_code_ff) begin
                  phase_in        = PH_DIGITS;
                  axis_is_tilt_in = 1'b1;
               end else if (req_rx_byte == max_pwm_code_ff) begin
                  emit      = 1'b1;
                  emit_kind = KIND_MAX_PWM;
               end else if (req_rx_byte == stop_code_ff) begin
                  emit      = 1'b1;
                  emit_kind = KIND_STOP;
               end
            end
            PH_DIGITS: begin
               idle_ticks_in  = 16'd0;
               value_accum_in = accum_new;
               digit_count_in = count_new;
               if (count_new >= NUM_DIGITS) begin
                  if (accum_new > MAX_DEGREES) begin
                     // out of range setpoint drops the command
                     phase_in       = PH_IDLE;
                     digit_count_in = 2'd0;
                     value_accum_in = 15'd0;
                  end else begin
                     phase_in       = PH_OFFSET;
                     digit_count_in = 2'd0;
                     emit           = 1'b1;
                     emit_kind      = axis_is_tilt_ff ? KIND_TILT_SETPOINT
                                                      : KIND_PAN_SETPOINT;
                     emit_value     = accum_new[8:0];
                  end
               end
            end
            PH_OFFSET: begin
               phase_in       = PH_IDLE;
               digit_count_in = 2'd0;
               value_accum_in = 15'd0;
               idle_ticks_in  = 16'd0;
               emit           = 1'b1;
               emit_kind      = axis_is_tilt_ff ? KIND_TILT_OFFSET : KIND_PAN_OFFSET;
               // offsets above the limit collapse to zero
               emit_value     = (digit > MAX_OFFSET) ? 9'd0 : {7'd0, digit[1:0]};
            end
            default: begin
               phase_in       = PH_IDLE;
               digit_count_in = 2'd0;
               value_accum_in = 15'd0;
               idle_ticks_in  = 16'd0;
            end
         endcase
      end
   end

   // result register load and drain
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (req_fire && emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = emit_kind;
         rsp_value_in = emit_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         axis_is_tilt_ff <= 1'b0;
         digit_count_ff  <= 2'd0;
         value_accum_ff  <= 15'd0;
         idle_ticks_ff   <= 16'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff        <= phase_in;
            axis_is_tilt_ff <= axis_is_tilt_in;
            digit_count_ff  <= digit_count_in;
            value_accum_ff  <= value_accum_in;
            idle_ticks_ff   <= idle_ticks_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
   end

endmodule

`default_nettype wire

>>> rtl/sscp_checker.sv
// ----------------------------------------------------------------------------
// sscp_checker
// port-level checks of the serial setpoint command parser
// ----------------------------------------------------------------------------
`default_nettype none

module sscp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_event_kind,
   input wire logic [8:0] rsp_event_value
);

   import sscp_pkg::*;

   // a waiting result is held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_event_kind) && $stable(rsp_event_value))
      else $error("stalled result changed");

   // no new request while the result register is full and blocked
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken over a blocked result");

   // values fit their kind
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_event_kind == KIND_PAN_SETPOINT || rsp_event_kind == KIND_TILT_SETPOINT)
            && rsp_event_value <= 9'd359)
         || ((rsp_event_kind == KIND_PAN_OFFSET || rsp_event_kind == KIND_TILT_OFFSET)
            && rsp_event_value <= 9'd2)
         || ((rsp_event_kind == KIND_MAX_PWM || rsp_event_kind == KIND_STOP)
            && rsp_event_value == 9'd0))
      else $error("result value out of range for its kind");

   // a result follows reset only after a request
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind serial_setpoint_command_parser sscp_checker u_sscp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_event_kind  (rsp_event_kind),
   .rsp_event_value (rsp_event_value)
);

`default_nettype wire

>>> bench/serial_setpoint_command_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_setpoint_command_parser_tb
// self-checking bench for the serial setpoint command parser: drives bytes and
// timer ticks with random gaps and result stalls, predicts every setpoint,
// offset and event in a scoreboard, and walks through several code and
// timeout settings written between phases
// ----------------------------------------------------------------------------

module serial_setpoint_command_parser_tb;
   import sscp_pkg::*;

   // bench limits
   localparam int unsigned MAX_GAP         = 12;
   localparam int unsigned SETTLE_CYCLES   = 4;
   localparam int unsigned NUM_PHASES      = 11;
   localparam int unsigned ITEMS_PER_PHASE = 100;
   localparam int unsigned CYCLE_LIMIT     = 400000;

   // one result of the parser
   typedef struct packed {
      logic [2:0] kind;
      logic [8:0] value;
   } parser_event_type;

   // ------------------------------------------------------------------------
   // scoreboard: tracks the parse state and register copies, queues the
   // result each accepted request should cause and checks results in order
   // ------------------------------------------------------------------------
   class setpoint_scoreboard_type;
      logic [7:0]       pan_code;
      logic [7:0]       tilt_code;
      logic [7:0]       max_pwm_code;
      logic [7:0]       stop_code;
      logic [15:0]      digit_timeout;
      phase_type        phase;
      logic             axis_tilt;
      logic [1:0]       digit_count;
      logic [14:0]      value_accum;
      logic [15:0]      idle_ticks;
      parser_event_type expected_events[$];
      int unsigned      failures;

      function new();
         pan_code      = PAN_CODE_RST;
         tilt_code     = TILT_CODE_RST;
         max_pwm_code  = MAX_PWM_CODE_RST;
         stop_code     = STOP_CODE_RST;
         digit_timeout = DIGIT_TIMEOUT_RST;
         axis_tilt     = 1'b0;
         failures      = 0;
         go_idle();
      endfunction

      function void go_idle();
         phase       = PH_IDLE;
         digit_count = '0;
         value_accum = '0;
         idle_ticks  = '0;
      endfunction

      function void start_digits(logic tilt);
         go_idle();
         axis_tilt = tilt;
         phase     = PH_DIGITS;
      endfunction

      function void push_event(logic [2:0] kind, logic [8:0] value);
         parser_event_type ev;
         ev.kind  = kind;
         ev.value = value;
         expected_events.push_back(ev);
      endfunction

      function int outstanding();
         return expected_events.size();
      endfunction

      function void write_register(logic [2:0] index, logic [15:0] data);
         case (index)
            CSR_PAN_CODE:      pan_code      = data[7:0];
            CSR_TILT_CODE:     tilt_code     = data[7:0];
            CSR_MAX_PWM_CODE:  max_pwm_code  = data[7:0];
            CSR_STOP_CODE:     stop_code     = data[7:0];
            CSR_DIGIT_TIMEOUT: digit_timeout = data;
            default: ;
         endcase
      endfunction

      function void note_request(logic cmd, logic [7:0] rx);
         logic [7:0]  digit;
         logic [16:0] next_ticks;
         logic [31:0] sum;
         digit = rx - ZERO_CHAR;
         if (cmd == CMD_TICK) begin
            // ticks only count while a digit or the offset is awaited
            if (phase inside {PH_DIGITS, PH_OFFSET}) begin
               next_ticks = {1'b0, idle_ticks} + 17'd1;
               if (next_ticks >= {1'b0, digit_timeout})
                  go_idle();
               else
                  idle_ticks = next_ticks[15:0];
            end
            return;
         end
         case (phase)
            PH_IDLE: begin
               if (rx == BACKSLASH_CHAR)
                  phase = PH_COMMAND;
            end
            PH_COMMAND: begin
               if (rx == S_CHAR)
                  phase = PH_TARGET;
               else
                  go_idle();
            end
            PH_TARGET: begin
               // first matching code wins: pan, tilt, max pwm, stop
               if (rx == pan_code)
                  start_digits(1'b0);
               else if (rx == tilt_code)
                  start_digits(1'b1);
               else begin
                  go_idle();
                  if (rx == max_pwm_code)
                     push_event(KIND_MAX_PWM, '0);
                  else if (rx == stop_code)
                     push_event(KIND_STOP, '0);
               end
            end
            PH_DIGITS: begin
               sum         = value_accum * 32'd10 + digit;
               value_accum = sum[14:0];
               idle_ticks  = '0;
               digit_count = digit_count + 2'd1;
               if (digit_count >= NUM_DIGITS) begin
                  if (value_accum > MAX_DEGREES)
                     go_idle();
                  else begin
                     phase       = PH_OFFSET;
                     digit_count = '0;
                     push_event(axis_tilt ? KIND_TILT_SETPOINT : KIND_PAN_SETPOINT,
                                value_accum[8:0]);
                  end
               end
            end
            PH_OFFSET: begin
               if (digit > MAX_OFFSET)
                  digit = '0;
               go_idle();
               push_event(axis_tilt ? KIND_TILT_OFFSET : KIND_PAN_OFFSET, {1'b0, digit});
            end
            default: go_idle();
         endcase
      endfunction

      function void check_result(logic [2:0] kind, logic [8:0] value);
         parser_event_type want;
         if (expected_events.size() == 0) begin
            $display("%0t: unexpected result, expected none, got kind %0d value %0d",
                     $time, kind, value);
            failures++;
            return;
         end
         want = expected_events.pop_front();
         if (want.kind !== kind) begin
            $display("%0t: event_kind expected %0d, got %0d", $time, want.kind, kind);
            failures++;
         end
         if (want.value !== value) begin
            $display("%0t: event_value expected %0d, got %0d", $time, want.value, value);
            failures++;
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // signals, all inputs known from time zero
   // ------------------------------------------------------------------------
   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_cmd     = CMD_BYTE;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_ready   = 1'b0;
   logic        csr_valid   = 1'b0;
   logic [2:0]  csr_index   = CSR_PAN_CODE;
   logic [15:0] csr_wdata   = '0;
   logic        req_ready;
   logic        rsp_valid;
   logic [2:0]  rsp_event_kind;
   logic [8:0]  rsp_event_value;
   logic        csr_ready;

   setpoint_scoreboard_type sb;
   int unsigned        items_sent  = 0;
   int unsigned        cycle_count = 0;
   // burst flags switch off the random idling for stretches
   logic               tx_burst    = 1'b0;
   logic               rx_burst    = 1'b0;

   serial_setpoint_command_parser u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_event_value (rsp_event_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // handshake monitor: values read right after the edge are the ones the
   // block sampled at that edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_request(req_cmd, req_rx_byte);
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_event_kind, rsp_event_value);
      if (!reset && csr_valid && csr_ready)
         sb.write_register(csr_index, csr_wdata);
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("serial_setpoint_command_parser: mismatch");
         $finish;
      end
   end

   // result side: random stall before each result, with bursts of none
   initial begin
      int unsigned stall;
      forever begin
         if ($urandom_range(0, 31) == 0)
            rx_burst = !rx_burst;
         stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do begin
            @(posedge clock);
         end while (!(rsp_valid && rsp_ready));
      end
   end

   // ------------------------------------------------------------------------
   // request driving
   // ------------------------------------------------------------------------

   // one request; valid stays high afterwards until the next gap or drain
   task automatic send_request(logic cmd, logic [7:0] rx);
      int unsigned gap;
      gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_rx_byte <= rx;
      do begin
         @(posedge clock);
      end while (!(req_valid && req_ready));
      items_sent++;
   endtask

   task automatic send_byte(logic [7:0] rx);
      send_request(CMD_BYTE, rx);
   endtask

   // ticks while a digit is awaited: mostly none, sometimes up to the timeout
   task automatic pause_ticks();
      int unsigned limit;
      int unsigned count;
      int unsigned pick;
      limit = 32'(sb.digit_timeout);
      pick  = $urandom_range(0, 19);
      if (pick < 12)
         count = 0;
      else if (pick < 18)
         count = $urandom_range(1, 3);
      else if (limit > 40)
         count = $urandom_range(4, 12);
      else if (limit == 0)
         count = 1;
      else
         count = limit - $urandom_range(0, 1);
      repeat (count) send_request(CMD_TICK, 8'($urandom));
   endtask

   // full setpoint command with ticks sprinkled into the waits
   task automatic send_setpoint(logic [7:0] target, logic [7:0] d0, logic [7:0] d1,
                                logic [7:0] d2, logic [7:0] offset);
      send_byte(BACKSLASH_CHAR);
      send_byte(S_CHAR);
      send_byte(target);
      pause_ticks();
      send_byte(d0);
      pause_ticks();
      send_byte(d1);
      pause_ticks();
      send_byte(d2);
      pause_ticks();
      send_byte(offset);
   endtask

   // command cut off while digits are still awaited
   task automatic partial_setpoint();
      send_byte(BACKSLASH_CHAR);
      send_byte(S_CHAR);
      send_byte(sb.pan_code);
      repeat ($urandom_range(0, 2)) begin
         pause_ticks();
         send_byte(ZERO_CHAR + 8'($urandom_range(0, 9)));
      end
      repeat ($urandom_range(0, 1)) send_request(CMD_TICK, 8'($urandom));
   endtask

   // stop requests and wait until every expected result has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] index, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do begin
         @(posedge clock);
      end while (!(csr_valid && csr_ready));
   endtask

   // one random sequence: mostly well-formed commands, some broken, some noise
   task automatic run_random_sequence();
      int unsigned pick;
      int unsigned degrees;
      logic [7:0]  digits [0:2];
      logic [7:0]  target;
      logic [7:0]  offset;
      tx_burst = ($urandom_range(0, 3) == 0);
      pick     = $urandom_range(0, 99);
      if (pick < 55) begin
         case ($urandom_range(0, 19))
            0:       degrees = 0;
            1:       degrees = 32'(MAX_DEGREES);
            2:       degrees = 32'(MAX_DEGREES) + 1;
            3:       degrees = $urandom_range(32'(MAX_DEGREES) + 1, 999);
            default: degrees = $urandom_range(0, 32'(MAX_DEGREES));
         endcase
         digits[0] = ZERO_CHAR + 8'(degrees / 100);
         digits[1] = ZERO_CHAR + 8'((degrees / 10) % 10);
         digits[2] = ZERO_CHAR + 8'(degrees % 10);
         // stray non-digit inside the digits now and then
         if ($urandom_range(0, 9) == 0)
            digits[$urandom_range(0, 2)] = 8'($urandom);
         target = $urandom_range(0, 1) ? sb.tilt_code : sb.pan_code;
         offset = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                              : ZERO_CHAR + 8'($urandom_range(0, 9));
         send_setpoint(target, digits[0], digits[1], digits[2], offset);
      end else if (pick < 70) begin
         send_byte(BACKSLASH_CHAR);
         send_byte(S_CHAR);
         send_byte($urandom_range(0, 1) ? sb.stop_code : sb.max_pwm_code);
      end else if (pick < 85) begin
         case ($urandom_range(0, 2))
            0: begin
               send_byte(BACKSLASH_CHAR);
               send_byte(8'($urandom));
            end
            1: begin
               send_byte(BACKSLASH_CHAR);
               send_byte(S_CHAR);
               send_byte(8'($urandom));
            end
            default: partial_setpoint();
         endcase
      end else begin
         repeat ($urandom_range(1, 6))
            send_request($urandom_range(0, 1) ? CMD_TICK : CMD_BYTE, 8'($urandom));
      end
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      int unsigned phase_start;
      logic [7:0]  pan;
      logic [7:0]  tilt;
      logic [7:0]  mpwm;
      logic [7:0]  stp;
      logic [7:0]  shared;
      logic [7:0]  junk;
      logic [15:0] tmo;
      logic [2:0]  spare_index;

      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part on the reset codes
      // largest setpoint with the largest offset
      send_setpoint(PAN_CODE_RST, "3", "5", "9", "2");
      // tick while idle is ignored
      send_request(CMD_TICK, 8'hFF);
      // colon as last digit still gives an accepted value, bad offset reads as 0
      send_setpoint(TILT_CODE_RST, "0", "0", ":", 8'hFF);
      // both immediate events
      send_byte(BACKSLASH_CHAR);
      send_byte(S_CHAR);
      send_byte(MAX_PWM_CODE_RST);
      send_byte(BACKSLASH_CHAR);
      send_byte(S_CHAR);
      send_byte(STOP_CODE_RST);
      // backslash twice drops back to idle
      send_byte(BACKSLASH_CHAR);
      send_byte(BACKSLASH_CHAR);
      // unknown target code
      send_byte(BACKSLASH_CHAR);
      send_byte(S_CHAR);
      send_byte(8'h00);
      // leave a command waiting so the next timeout write lands mid-wait
      partial_setpoint();
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         // default: random letter codes and a short timeout
         pan    = "a" + 8'($urandom_range(0, 25));
         tilt   = "a" + 8'($urandom_range(0, 25));
         mpwm   = "a" + 8'($urandom_range(0, 25));
         stp    = "a" + 8'($urandom_range(0, 25));
         shared = 8'($urandom);
         junk   = 8'($urandom);
         tmo    = 16'($urandom_range(2, 24));
         case (p)
            1: tmo = 16'd1;
            2: tmo = 16'd0;
            // all codes equal, pan must win
            3: begin
               pan  = shared;
               tilt = shared;
               mpwm = shared;
               stp  = shared;
            end
            // tilt shares its code with both events
            4: begin
               tilt = shared;
               mpwm = shared;
               stp  = shared;
            end
            // max pwm wins over stop
            5: begin
               mpwm = shared;
               stp  = shared;
            end
            // extreme code bytes and the longest timeout
            6: begin
               pan  = 8'h00;
               tilt = 8'hFF;
               mpwm = BACKSLASH_CHAR;
               stp  = S_CHAR;
               tmo  = 16'hFFFF;
            end
            // back to the reset values
            7: begin
               pan  = PAN_CODE_RST;
               tilt = TILT_CODE_RST;
               mpwm = MAX_PWM_CODE_RST;
               stp  = STOP_CODE_RST;
               tmo  = DIGIT_TIMEOUT_RST;
            end
            default: ;
         endcase

         // upper data bits are junk for the 8 bit code registers
         write_csr(CSR_PAN_CODE, {junk, pan});
         write_csr(CSR_TILT_CODE, {~junk, tilt});
         write_csr(CSR_MAX_PWM_CODE, {junk, mpwm});
         write_csr(CSR_STOP_CODE, {~junk, stp});
         write_csr(CSR_DIGIT_TIMEOUT, tmo);
         // writes past the register list must change nothing
         if (p == 7 || p == 2) begin
            spare_index = CSR_DIGIT_TIMEOUT;
            do begin
               spare_index++;
               write_csr(spare_index, 16'($urandom));
            end while (spare_index != '1);
         end
         csr_valid <= 1'b0;

         // first ticks hit the command left waiting under the new timeout
         tx_burst = 1'b0;
         repeat ($urandom_range(1, 3)) send_request(CMD_TICK, 8'($urandom));

         phase_start = items_sent;
         while (items_sent - phase_start < ITEMS_PER_PHASE)
            run_random_sequence();
         partial_setpoint();
         drain();
      end

      if (sb.failures == 0 && sb.outstanding() == 0)
         $display("serial_setpoint_command_parser: match");
      else
         $display("serial_setpoint_command_parser: mismatch");
      $finish;
   end

endmodule

>>> files.f
rtl/sscp_pkg.sv
rtl/serial_setpoint_command_parser.sv
rtl/sscp_checker.sv
bench/serial_setpoint_command_parser_tb.sv
